FILE: rtl/core/wmfs_pkg.sv
// Shared widths, register indexes and stage types for the wavetable mip frame selector.
// No dependencies; every other file of the block imports this package.
package wmfs_pkg;

   localparam int FRAME_SIZE_DEF = 2048;
   localparam int MAX_FRAMES_DEF = 256;

   // Field widths fixed by the interface.
   localparam int POS_W      = 18;
   localparam int FREQ_W     = 24;
   localparam int RATE_W     = 19;
   localparam int NFRAMES_W  = 9;
   localparam int LVL_W      = 4;
   localparam int FRAME_W    = 8;
   localparam int FRAC_W     = 16;
   localparam int ROW_W      = 23;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = RATE_W;

   // Internal widths.
   localparam int QPOS_W    = FRAC_W + 1;          // clamped position 0..1.0
   localparam int SCALED_W  = QPOS_W + NFRAMES_W;  // position times last frame
   localparam int FREQ40_W  = FREQ_W + 6;          // note_freq * 40
   localparam int LIMIT_W   = RATE_W + 13;         // sample_rate * 19 * 256

   localparam logic [QPOS_W-1:0] ONE_Q16       = QPOS_W'(65536);
   localparam logic [FREQ_W-1:0] LOW_NOTE_FREQ = FREQ_W'(256);

   localparam logic [RATE_W-1:0]    SAMPLE_RATE_RST = RATE_W'(48000);
   localparam logic [NFRAMES_W-1:0] NUM_FRAMES_RST  = '0;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_FRAMES  = 1'b1;

   // Frame indexes carry the full num_frames range; outputs keep the low bits.
   typedef struct packed {
      logic [NFRAMES_W-1:0] frame_lo;
      logic [NFRAMES_W-1:0] frame_hi;
      logic [FRAC_W-1:0]    frame_frac;
   } frame_type;

   typedef struct packed {
      logic             valid_res;
      logic [LVL_W-1:0] mip_level;
      frame_type        frame;
   } mid_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_lo;
      logic [ROW_W-1:0] row_hi;
   } row_type;

endpackage

FILE: rtl/core/wmfs_level_sel.sv
// Band-limit level selection: compares harmonic count times frequency against the
// Nyquist margin for each finer level at once, takes the first to pass. Uses wmfs_pkg.
module wmfs_level_sel
   import wmfs_pkg::*;
#(
   parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
   input  logic [FREQ_W-1:0] note_freq,
   input  logic [RATE_W-1:0] sample_rate,
   output logic [LVL_W-1:0]  mip_level
);

   localparam int HALF   = FRAME_SIZE / 2;
   localparam int HALF_W = $clog2(HALF + 1);
   localparam int LEVELS = HALF_W;
   localparam int LAST   = LEVELS - 1;
   localparam int CMP_W  = FREQ40_W + HALF_W;

   logic [FREQ40_W-1:0] freq40;
   logic [LIMIT_W-1:0]  limit;
   logic [LAST-1:0]     pass;

   // 40 = 32 + 8 and 19 * 256 = 4096 + 512 + 256.
   assign freq40 = (FREQ40_W'(note_freq) << 5) + (FREQ40_W'(note_freq) << 3);
   assign limit  = (LIMIT_W'(sample_rate) << 12) + (LIMIT_W'(sample_rate) << 9)
                 + (LIMIT_W'(sample_rate) << 8);

   always_comb begin
      for (int k = 0; k < LAST; k++) begin
         pass[k] = (CMP_W'(freq40) * CMP_W'(HALF >> k)) <= CMP_W'(limit);
      end
   end

   // The last level is taken when no finer level passes; low notes take level 0.
   always_comb begin
      mip_level = LVL_W'(LAST);
      for (int k = LAST - 1; k >= 0; k--) begin
         if (pass[k]) begin
            mip_level = LVL_W'(k);
         end
      end
      if (note_freq <= LOW_NOTE_FREQ) begin
         mip_level = '0;
      end
   end

endmodule

FILE: rtl/core/wmfs_frame_map.sv
// Morph position to frame pair: clamps the position to 0..1, scales it by the last
// frame index and splits it into frames and blend fraction. Uses wmfs_pkg.
module wmfs_frame_map
   import wmfs_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
   input  logic signed [POS_W-1:0] frame_pos,
   input  logic [NFRAMES_W-1:0]    num_frames,
   output frame_type               frame
);

   // Above this count the table limit applies; a 9-bit count never exceeds 511.
   localparam int NF_CAP = (MAX_FRAMES < 511) ? MAX_FRAMES : 511;

   logic [NFRAMES_W-1:0] nf_eff;
   logic [NFRAMES_W-1:0] last_frame;
   logic [QPOS_W-1:0]    pos_q;
   logic [SCALED_W-1:0]  scaled;
   logic [NFRAMES_W-1:0] f0;

   always_comb begin
      if (num_frames > NFRAMES_W'(NF_CAP)) begin
         nf_eff = NFRAMES_W'(NF_CAP);
      end else begin
         nf_eff = num_frames;
      end
   end

   assign last_frame = nf_eff - NFRAMES_W'(1);

   always_comb begin
      if (frame_pos[POS_W-1]) begin
         pos_q = '0;
      end else if (frame_pos[QPOS_W-1:0] > ONE_Q16) begin
         pos_q = ONE_Q16;
      end else begin
         pos_q = frame_pos[QPOS_W-1:0];
      end
   end

   assign scaled = SCALED_W'(pos_q) * SCALED_W'(last_frame);
   // The position never exceeds 1.0, so the integer part stays within the last frame.
   assign f0     = scaled[FRAC_W +: NFRAMES_W];

   always_comb begin
      frame.frame_lo   = f0;
      frame.frame_frac = scaled[FRAC_W-1:0];
      if (f0 < last_frame) begin
         frame.frame_hi = f0 + NFRAMES_W'(1);
      end else begin
         frame.frame_hi = last_frame;
      end
   end

endmodule

FILE: rtl/core/wmfs_row_addr.sv
// Row start offsets in the table store for the chosen level and both frames.
// Uses wmfs_pkg; offsets wrap at the row address width.
module wmfs_row_addr
   import wmfs_pkg::*;
#(
   parameter int FRAME_SIZE = FRAME_SIZE_DEF,
   parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
   input  mid_type mid,
   output row_type rows
);

   logic [ROW_W-1:0] stride;

   assign stride      = ROW_W'(mid.mip_level) * ROW_W'(MAX_FRAMES);
   assign rows.row_lo = (stride + ROW_W'(mid.frame.frame_lo)) * ROW_W'(FRAME_SIZE);
   assign rows.row_hi = (stride + ROW_W'(mid.frame.frame_hi)) * ROW_W'(FRAME_SIZE);

endmodule

FILE: rtl/core/wavetable_mip_frame_selector.sv
// A request is held in the request register and then in the response register.
// Throughput: one request per cycle; a stalled response holds the request register only
// once both the request register and the response register are full.
// Reset (synchronous, active high) empties both registers and loads sample_rate = 48000
// and num_frames = 0. Uses wmfs_pkg, wmfs_level_sel, wmfs_frame_map and wmfs_row_addr.
module wavetable_mip_frame_selector
   import wmfs_pkg::*;
#(
   parameter int FRAME_SIZE = FRAME_SIZE_DEF,
   parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [POS_W-1:0] req_frame_pos,
   input  logic [FREQ_W-1:0]       req_note_freq,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_valid_res,
   output logic [LVL_W-1:0]        rsp_mip_level,
   output logic [FRAME_W-1:0]      rsp_frame_lo,
   output logic [FRAME_W-1:0]      rsp_frame_hi,
   output logic [FRAC_W-1:0]       rsp_frame_frac,
   output logic [ROW_W-1:0]        rsp_row_lo_start,
   output logic [ROW_W-1:0]        rsp_row_hi_start
);

   logic [RATE_W-1:0]    sample_rate_ff;
   logic [NFRAMES_W-1:0] num_frames_ff;

   logic                    s1_valid_ff;
   logic signed [POS_W-1:0] s1_pos_ff;
   logic [FREQ_W-1:0]       s1_freq_ff;

   mid_type mid_sel;

   logic               out_valid_ff;
   logic               out_valid_res_ff;
   logic [LVL_W-1:0]   out_level_ff;
   logic [FRAME_W-1:0] out_lo_ff;
   logic [FRAME_W-1:0] out_hi_ff;
   logic [FRAC_W-1:0]  out_frac_ff;
   logic [ROW_W-1:0]   out_row_lo_ff;
   logic [ROW_W-1:0]   out_row_hi_ff;

   logic       out_ready;
   logic       s1_ready;
   logic [LVL_W-1:0] level;
   frame_type  frame;
   row_type    rows;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= SAMPLE_RATE_RST;
         num_frames_ff  <= NUM_FRAMES_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SAMPLE_RATE: sample_rate_ff <= csr_wdata;
            CSR_NUM_FRAMES:  num_frames_ff  <= csr_wdata[NFRAMES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Each stage moves on when it is empty or the next one can take its request.
   assign out_ready = !out_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign req_ready = s1_ready;

   // Stage 1: request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_pos_ff  <= req_frame_pos;
         s1_freq_ff <= req_note_freq;
      end
   end

   wmfs_level_sel #(
      .FRAME_SIZE (FRAME_SIZE)
   ) u_level_sel (
      .note_freq   (s1_freq_ff),
      .sample_rate (sample_rate_ff),
      .mip_level   (level)
   );

   wmfs_frame_map #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_frame_map (
      .frame_pos  (s1_pos_ff),
      .num_frames (num_frames_ff),
      .frame      (frame)
   );

   // Without a table every field of the response is zero.
   always_comb begin
      if (num_frames_ff == '0) begin
         mid_sel = '0;
      end else begin
         mid_sel.valid_res = 1'b1;
         mid_sel.mip_level = level;
         mid_sel.frame     = frame;
      end
   end

   wmfs_row_addr #(
      .FRAME_SIZE (FRAME_SIZE),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_row_addr (
      .mid  (mid_sel),
      .rows (rows)
   );

   // Stage 2: response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         out_valid_res_ff <= mid_sel.valid_res;
         out_level_ff     <= mid_sel.mip_level;
         out_lo_ff        <= mid_sel.frame.frame_lo[FRAME_W-1:0];
         out_hi_ff        <= mid_sel.frame.frame_hi[FRAME_W-1:0];
         out_frac_ff      <= mid_sel.frame.frame_frac;
         out_row_lo_ff    <= rows.row_lo;
         out_row_hi_ff    <= rows.row_hi;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_valid_res    = out_valid_res_ff;
   assign rsp_mip_level    = out_level_ff;
   assign rsp_frame_lo     = out_lo_ff;
   assign rsp_frame_hi     = out_hi_ff;
   assign rsp_frame_frac   = out_frac_ff;
   assign rsp_row_lo_start = out_row_lo_ff;
   assign rsp_row_hi_start = out_row_hi_ff;

   // A request held in stage 1 must not vanish while the response register is blocked.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_ready) |=> s1_valid_ff)
      else $error("stage 1 request dropped while the response register was blocked");

   // The upper frame is the lower frame or the one after it.
   a_frame_pair: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && mid_sel.valid_res) |->
      (mid_sel.frame.frame_hi == mid_sel.frame.frame_lo ||
       mid_sel.frame.frame_hi == mid_sel.frame.frame_lo + NFRAMES_W'(1)))
      else $error("upper frame is not adjacent to the lower frame");

   // A response without a table carries only zeros.
   a_empty_cursor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |->
      (rsp_mip_level == '0 && rsp_frame_lo == '0 && rsp_frame_hi == '0 &&
       rsp_frame_frac == '0 && rsp_row_lo_start == '0 && rsp_row_hi_start == '0))
      else $error("response without a table has nonzero fields");

   // The level never goes past the coarsest one.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (mid_sel.mip_level <= LVL_W'($clog2(FRAME_SIZE / 2 + 1) - 1)))
      else $error("mip level beyond the last level");

endmodule

FILE: verif/tb_wavetable_mip_frame_selector.sv
`timescale 1ns / 100ps
// Self-checking testbench for wavetable_mip_frame_selector: random and directed requests
// against a built-in predictor of the level, frame and row offsets under changing settings.
// Depends on wmfs_pkg and the block's RTL only.
module tb_wavetable_mip_frame_selector;
   import wmfs_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 6;
   localparam int IDLE_PCT        = 36;
   localparam int SETTLE_CYCLES   = 8;
   localparam int STALL_LIMIT     = 2000;
   // 0.475 of the sample rate, with the note frequency in 1/256 Hz steps.
   localparam int NYQ_NUM         = 19;
   localparam int NYQ_DEN         = 40;
   localparam int HZ_STEPS        = 256;
   localparam int TOP_LEVEL       = 10;
   localparam int SAMPLE_RATE_MAX = 2**RATE_W - 1;
   localparam int NUM_FRAMES_MAX  = 2**NFRAMES_W - 1;
   localparam int FREQ_MAX        = 2**FREQ_W - 1;

   typedef struct packed {
      logic               valid_res;
      logic [LVL_W-1:0]   mip_level;
      logic [FRAME_W-1:0] frame_lo;
      logic [FRAME_W-1:0] frame_hi;
      logic [FRAC_W-1:0]  frame_frac;
      logic [ROW_W-1:0]   row_lo_start;
      logic [ROW_W-1:0]   row_hi_start;
   } selection_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [POS_W-1:0] req_frame_pos;
   logic [FREQ_W-1:0]       req_note_freq;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_valid_res;
   logic [LVL_W-1:0]        rsp_mip_level;
   logic [FRAME_W-1:0]      rsp_frame_lo;
   logic [FRAME_W-1:0]      rsp_frame_hi;
   logic [FRAC_W-1:0]       rsp_frame_frac;
   logic [ROW_W-1:0]        rsp_row_lo_start;
   logic [ROW_W-1:0]        rsp_row_hi_start;

   logic [RATE_W-1:0]    rate_cfg   = SAMPLE_RATE_RST;
   logic [NFRAMES_W-1:0] frames_cfg = NUM_FRAMES_RST;
   selection_type        pending_selections[$];
   selection_type        oldest_selection;
   bit                   steady;
   int                   mismatches;
   int                   stall_cycles;

   wavetable_mip_frame_selector u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_pos    (req_frame_pos),
      .req_note_freq    (req_note_freq),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_mip_level    (rsp_mip_level),
      .rsp_frame_lo     (rsp_frame_lo),
      .rsp_frame_hi     (rsp_frame_hi),
      .rsp_frame_frac   (rsp_frame_frac),
      .rsp_row_lo_start (rsp_row_lo_start),
      .rsp_row_hi_start (rsp_row_hi_start)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic selection_type predict_selection(input logic signed [POS_W-1:0] pos,
                                                       input logic [FREQ_W-1:0] freq);
      selection_type     sel;
      int unsigned       last_frame;
      logic [QPOS_W-1:0] qpos;
      longint unsigned   scaled, lo, hi, harm, limit, lvl;
      sel = '0;
      if (frames_cfg == 0) return sel;
      last_frame = ((frames_cfg > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frames_cfg) - 1;
      if (pos < 0) qpos = '0;
      else if (pos > 65536) qpos = ONE_Q16;
      else qpos = pos[QPOS_W-1:0];
      scaled = 64'(qpos) * last_frame;
      lo = scaled >> FRAC_W;
      hi = (lo + 1 > last_frame) ? last_frame : lo + 1;
      // Walk down the levels, halving the harmonic count, until the top harmonic
      // fits under the Nyquist margin; the last level is taken when none fits.
      lvl = 0;
      if (freq > LOW_NOTE_FREQ) begin
         limit = 64'(NYQ_NUM * HZ_STEPS) * 64'(rate_cfg);
         harm = FRAME_SIZE_DEF / 2;
         while (harm > 1 && harm * 64'(freq) * NYQ_DEN > limit) begin
            harm = harm >> 1;
            lvl++;
         end
      end
      sel.valid_res    = 1'b1;
      sel.mip_level    = LVL_W'(lvl);
      sel.frame_lo     = FRAME_W'(lo);
      sel.frame_hi     = FRAME_W'(hi);
      sel.frame_frac   = FRAC_W'(scaled);
      sel.row_lo_start = ROW_W'((lvl * MAX_FRAMES_DEF + lo) * FRAME_SIZE_DEF);
      sel.row_hi_start = ROW_W'((lvl * MAX_FRAMES_DEF + hi) * FRAME_SIZE_DEF);
      return sel;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_selections.size() == 0) begin
            mismatches++;
            $display("%0t: response with no request pending, expected none, got level %0d",
                     $time, rsp_mip_level);
         end else begin
            oldest_selection = pending_selections.pop_front();
            check_field("valid_res", oldest_selection.valid_res, rsp_valid_res);
            check_field("mip_level", oldest_selection.mip_level, rsp_mip_level);
            check_field("frame_lo", oldest_selection.frame_lo, rsp_frame_lo);
            check_field("frame_hi", oldest_selection.frame_hi, rsp_frame_hi);
            check_field("frame_frac", oldest_selection.frame_frac, rsp_frame_frac);
            check_field("row_lo_start", oldest_selection.row_lo_start, rsp_row_lo_start);
            check_field("row_hi_start", oldest_selection.row_hi_start, rsp_row_hi_start);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_request(input logic signed [POS_W-1:0] pos,
                               input logic [FREQ_W-1:0] freq);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_frame_pos <= pos;
      req_note_freq <= freq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_selections.insert(pending_selections.size(), predict_selection(pos, freq));
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (pending_selections.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= CSR_DATA_W'(data);
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_SAMPLE_RATE) rate_cfg = RATE_W'(data);
      else frames_cfg = NFRAMES_W'(data);
      @(posedge clock);
   endtask

   // Mostly in-range positions, some right at the clamp edges, and frequencies often right at a
   // level's pass limit or low, with the rest spread over every value the fields can carry.
   task automatic run_random(input int count);
      logic signed [POS_W-1:0] pos;
      logic [FREQ_W-1:0]       freq;
      longint                  bound;
      int unsigned             pick, lvl;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) pos = POS_W'($urandom_range(0, 65536));
         else if (pick < 80)
            pos = POS_W'(($urandom_range(0, 1) ? 65536 : 0) + int'($urandom_range(0, 4)) - 2);
         else pos = POS_W'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            lvl = $urandom_range(0, TOP_LEVEL);
            bound = longint'(NYQ_NUM * HZ_STEPS) * longint'(rate_cfg)
                    / (NYQ_DEN * ((FRAME_SIZE_DEF / 2) >> lvl))
                    + int'($urandom_range(0, 2)) - 1;
            if (bound < 0) bound = 0;
            if (bound > FREQ_MAX) bound = FREQ_MAX;
            freq = FREQ_W'(bound);
         end else if (pick < 70) begin
            freq = FREQ_W'($urandom);
         end else if (pick < 85) begin
            freq = FREQ_W'($urandom_range(0, 512));
         end else begin
            freq = FREQ_W'($urandom >> $urandom_range(8, 31));
         end
         send_request(pos, freq);
      end
   endtask

   task automatic apply_setting(input int unsigned rate, input int unsigned frames,
                                input int count);
      wait_for_responses();
      write_csr(CSR_SAMPLE_RATE, rate);
      write_csr(CSR_NUM_FRAMES, frames);
      run_random(count);
   endtask

   // Straight out of reset there is no table, so every response is empty.
   task automatic test_no_table();
      run_random(8);
   endtask

   task automatic test_directed_extremes();
      int dir_pos[12]  = '{-131072, -1, 0, 1, 32768, 65535, 65536, 65537, 131071,
                           87381, -87382, 4096};
      int dir_freq[12] = '{0, 256, 257, 16777215, 112640, 1234567, 11184810, 5592405,
                           255, 5700, 5701, 1};
      wait_for_responses();
      write_csr(CSR_NUM_FRAMES, MAX_FRAMES_DEF);
      for (int i = 0; i < 12; i++) send_request(POS_W'(dir_pos[i]), FREQ_W'(dir_freq[i]));
   endtask

   task automatic test_frame_counts();
      apply_setting(48000, 1, 140);
      apply_setting(48000, 2, 140);
      apply_setting(96000, 255, 140);
      apply_setting(44100, MAX_FRAMES_DEF + 1, 140);
      apply_setting(22050, NUM_FRAMES_MAX, 140);
   endtask

   task automatic test_rate_extremes();
      apply_setting(0, 100, 140);
      apply_setting(8000, MAX_FRAMES_DEF, 140);
      apply_setting(384000, 64, 140);
      apply_setting(SAMPLE_RATE_MAX, 3, 140);
   endtask

   task automatic test_full_rate();
      steady = 1'b1;
      apply_setting(48000, 200, 250);
      steady = 1'b0;
   endtask

   task automatic test_pause_for_drain();
      for (int r = 0; r < 3; r++) begin
         run_random(40);
         wait_for_responses();
      end
   endtask

   task automatic test_random_settings();
      for (int r = 0; r < 4; r++)
         apply_setting($urandom_range(0, SAMPLE_RATE_MAX), $urandom_range(0, NUM_FRAMES_MAX),
                       60);
   endtask

   task automatic test_table_removed();
      apply_setting(48000, 0, 60);
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      csr_write_en  = 1'b0;
      csr_index     = CSR_SAMPLE_RATE;
      csr_wdata     = '0;
      req_valid     = 1'b0;
      req_frame_pos = '0;
      req_note_freq = '0;
      rsp_ready     = 1'b0;
      steady        = 1'b0;
      mismatches    = 0;
      stall_cycles  = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_table();
      test_directed_extremes();
      test_frame_counts();
      test_rate_extremes();
      test_full_rate();
      test_pause_for_drain();
      test_random_settings();
      test_table_removed();
      wait_for_responses();

      if (mismatches == 0 && pending_selections.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/wmfs_pkg.sv
rtl/core/wmfs_level_sel.sv
rtl/core/wmfs_frame_map.sv
rtl/core/wmfs_row_addr.sv
rtl/core/wavetable_mip_frame_selector.sv
verif/tb_wavetable_mip_frame_selector.sv
